FILE: hw/rtl/xsg_pkg.sv
package xsg_pkg;

   localparam int unsigned WordBits     = 64;
   localparam int unsigned HalfBits     = 32;
   localparam int unsigned FracBits     = 53;
   localparam int unsigned NumWords     = 4;
   localparam int unsigned WordIdxBits  = 2;

   localparam logic [WordBits-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WordBits-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WordBits-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

   localparam logic OP_SEED = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [WordBits-1:0] seed_value;
   } req_type;

   typedef struct packed {
      logic [WordBits-1:0] random_word;
      logic [FracBits-1:0] unit_fraction;
      logic                fraction_zero;
   } rsp_type;

   // shared multiplier, control towards it
   typedef struct packed {
      logic                start;
      logic [WordBits-1:0] multiplicand;
      logic [WordBits-1:0] multiplier;
   } mul_req_type;

   typedef struct packed {
      logic                done;
      logic                busy;
      logic [WordBits-1:0] product;
   } mul_rsp_type;

endpackage

FILE: hw/rtl/xoshiro256ss_generator_unit.sv
// channel | direction | handshake            | word
// req_    | in        | req_valid / req_stall | xsg_pkg::req_type (operation, seed_value)
// rsp_    | out       | rsp_valid / rsp_stall | xsg_pkg::rsp_type (word, fraction, zero flag)
//
// A draw passes from acceptance through times five, then rotate/times nine with state
// advance, before the next acceptance. A seed makes four words, each two passes through
// the multiplier (low 64 bits from 32x32 partial products).
// Reset (synchronous) clears the state words, so draws before a seed give zero.
// req_stall is high while an item is in work; a draw waits for the output register
// when rsp_stall holds a previous word there.
module xoshiro256ss_generator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  xsg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output xsg_pkg::rsp_type rsp_data
);

   localparam int unsigned W  = xsg_pkg::WordBits;
   localparam int unsigned IW = xsg_pkg::WordIdxBits;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_ADD       = 4'd1;
   localparam logic [3:0] ST_MUL_A_GO  = 4'd2;
   localparam logic [3:0] ST_MUL_A_WT  = 4'd3;
   localparam logic [3:0] ST_MUL_B_GO  = 4'd4;
   localparam logic [3:0] ST_MUL_B_WT  = 4'd5;
   localparam logic [3:0] ST_WRITE     = 4'd6;
   localparam logic [3:0] ST_DRAW_MUL  = 4'd7;
   localparam logic [3:0] ST_DRAW_OUT  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [W-1:0]      words_ff [xsg_pkg::NumWords];
   logic [W-1:0]      words_in [xsg_pkg::NumWords];
   logic [IW-1:0]     idx_ff, idx_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   xsg_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   xsg_pkg::mul_req_type mul_req;
   xsg_pkg::mul_rsp_type mul_rsp;

   logic          accept;
   logic [W-1:0]  rot;
   logic [W-1:0]  draw_word;
   logic [W-1:0]  s2x, s3x;

   xsg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign rot       = {acc_ff[W-8:0], acc_ff[W-1:W-7]};
   assign draw_word = rot + {rot[W-4:0], 3'b000};

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      words_in     = words_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_req      = '0;
      s2x          = words_ff[2] ^ words_ff[0];
      s3x          = words_ff[3] ^ words_ff[1];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.operation == xsg_pkg::OP_SEED) begin
                  acc_in   = req_data.seed_value + xsg_pkg::GOLDEN_STEP;
                  idx_in   = '0;
                  state_in = ST_ADD;
               end else begin
                  state_in = ST_DRAW_MUL;
               end
            end
         end
         ST_ADD: begin
            acc_in   = acc_ff + xsg_pkg::GOLDEN_STEP;
            state_in = ST_MUL_A_GO;
         end
         ST_MUL_A_GO: begin
            mul_req.start        = 1'b1;
            mul_req.multiplicand = acc_ff ^ (acc_ff >> 30);
            mul_req.multiplier   = xsg_pkg::MIX_MUL_A;
            state_in             = ST_MUL_A_WT;
         end
         ST_MUL_A_WT: begin
            if (mul_rsp.done) state_in = ST_MUL_B_GO;
         end
         ST_MUL_B_GO: begin
            mul_req.start        = 1'b1;
            mul_req.multiplicand = mul_rsp.product ^ (mul_rsp.product >> 27);
            mul_req.multiplier   = xsg_pkg::MIX_MUL_B;
            state_in             = ST_MUL_B_WT;
         end
         ST_MUL_B_WT: begin
            if (mul_rsp.done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            words_in[idx_ff] = mul_rsp.product ^ (mul_rsp.product >> 31);
            idx_in           = idx_ff + 1'b1;
            state_in         = (idx_ff == IW'(xsg_pkg::NumWords - 1)) ? ST_IDLE : ST_ADD;
         end
         ST_DRAW_MUL: begin
            // s1 * 5
            acc_in   = words_ff[1] + {words_ff[1][W-3:0], 2'b00};
            state_in = ST_DRAW_OUT;
         end
         ST_DRAW_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.random_word   = draw_word;
               rsp_data_in.unit_fraction = draw_word[W-1:W-xsg_pkg::FracBits];
               rsp_data_in.fraction_zero = (draw_word[W-1:W-xsg_pkg::FracBits] == '0);
               words_in[0] = words_ff[0] ^ s3x;
               words_in[1] = words_ff[1] ^ s2x;
               words_in[2] = s2x ^ {words_ff[1][W-18:0], 17'd0};
               words_in[3] = {s3x[W-46:0], s3x[W-1:W-45]};
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < xsg_pkg::NumWords; i++) words_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         words_ff     <= words_in;
      end
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/xsg_mul.sv
module xsg_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  xsg_pkg::mul_req_type mul_req,
   output xsg_pkg::mul_rsp_type mul_rsp
);

   localparam int unsigned W = xsg_pkg::WordBits;
   localparam int unsigned H = xsg_pkg::HalfBits;

   // low 64 bits of a*b from three 32x32 partial products
   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_LH = 2'd1;
   localparam logic [1:0] STEP_HL = 2'd2;
   localparam logic [1:0] STEP_SUM = 2'd3;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [1:0]   step_ff, step_in;
   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] part_ff, part_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [H-1:0] op_a, op_b;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      op_a    = a_ff[H-1:0];
      op_b    = b_ff[H-1:0];
      case (step_ff)
         STEP_LL: begin
            op_a = a_ff[H-1:0];
            op_b = b_ff[H-1:0];
         end
         STEP_LH: begin
            op_a = a_ff[H-1:0];
            op_b = b_ff[W-1:H];
         end
         STEP_HL: begin
            op_a = a_ff[W-1:H];
            op_b = b_ff[H-1:0];
         end
         default: begin
            op_a = a_ff[H-1:0];
            op_b = b_ff[H-1:0];
         end
      endcase
      part_in = op_a * op_b;

      if (mul_req.start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = STEP_LL;
         a_in    = mul_req.multiplicand;
         b_in    = mul_req.multiplier;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         unique case (step_ff)
            STEP_LL:  ;
            STEP_LH:  acc_in = part_ff;
            STEP_HL:  acc_in = acc_ff + {part_ff[H-1:0], {H{1'b0}}};
            STEP_SUM: begin
               acc_in  = acc_ff + {part_ff[H-1:0], {H{1'b0}}};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      part_ff <= part_in;
      acc_ff  <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.busy    = busy_ff;
   assign mul_rsp.product = acc_ff;

endmodule

FILE: hw/rtl/xsg_checker.sv
module xsg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input xsg_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input xsg_pkg::rsp_type rsp_data
);

   // a pending word is not dropped
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken while previous item in work");

   // a seed accepted while no word is pending raises no word right after it
   a_seed_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.operation == xsg_pkg::OP_SEED) && !rsp_valid
      |=> !rsp_valid)
      else $error("rsp word after seed");

   a_fields_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.unit_fraction == rsp_data.random_word[63:11]) &&
                    (rsp_data.fraction_zero == (rsp_data.unit_fraction == '0)))
      else $error("rsp fraction fields disagree with word");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid straight after reset");

endmodule

bind xoshiro256ss_generator_unit xsg_checker u_xsg_checker (.*);
